[src/vrpv_pkg.sv]
// Shared types and constants of the vertex rotate / project / viewport block.
// No dependencies; the divider stage, the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package vrpv_pkg;

    localparam int DEF_COORD_BITS     = 12;
    localparam int DEF_TRIG_FRAC_BITS = 14;

    localparam int TRIG_W    = 16;  // sine, cosine and depth offset registers
    localparam int FOCAL_W   = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 16;
    localparam int QBITS     = 17;  // quotient bits needed to decide saturation
    localparam int KW        = 11;  // signed width of the viewport constants

    // Viewport mapping constants.
    localparam logic signed [KW-1:0] K_X_CTR = 11'sd399;
    localparam logic signed [KW-1:0] K_X_DEN = 11'sd799;
    localparam logic signed [KW-1:0] K_X_SCR = 11'sd639;
    localparam logic signed [KW-1:0] K_Y_CTR = 11'sd299;
    localparam logic signed [KW-1:0] K_Y_DEN = 11'sd599;
    localparam logic signed [KW-1:0] K_Y_SCR = 11'sd479;

    localparam logic [PIX_W:0] PIX_POS_MAX = 17'd32767;
    localparam logic [PIX_W:0] PIX_NEG_MAX = 17'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIN_FIRST    = 3'd0,
        REG_COS_FIRST    = 3'd1,
        REG_SIN_SECOND   = 3'd2,
        REG_COS_SECOND   = 3'd3,
        REG_SIN_THIRD    = 3'd4,
        REG_COS_THIRD    = 3'd5,
        REG_DEPTH_OFFSET = 3'd6,
        REG_FOCAL_LENGTH = 3'd7
    } t_reg_idx;

    localparam logic [TRIG_W-1:0]  RST_SIN   = 16'd0;
    localparam logic [TRIG_W-1:0]  RST_COS   = 16'd16384;
    localparam logic [TRIG_W-1:0]  RST_OFF   = 16'hFF6A;
    localparam logic [FOCAL_W-1:0] RST_FOCAL = 12'd1200;

    // Sideband that travels with each lane through the divider.
    typedef struct packed {
        logic neg;   // quotient is negative
        logic ovf;   // quotient magnitude needs more than QBITS bits
        logic zero;  // translated depth was zero
    } t_div_side;

endpackage

`default_nettype wire

[src/vrpv_vtx_if.sv]
// Vertex input channel: valid/ready handshake with the three coordinates.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vrpv_vtx_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] vz;

    modport source (output valid, vx, vy, vz, input ready);
    modport sink   (input valid, vx, vy, vz, output ready);
endinterface

`default_nettype wire

[src/vrpv_pix_if.sv]
// Pixel output channel: valid/ready handshake with screen position and flags.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vrpv_pix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               depth_zero;
    logic               clipped;

    modport source (output valid, pixel_x, pixel_y, depth_zero, clipped, input ready);
    modport sink   (input valid, pixel_x, pixel_y, depth_zero, clipped, output ready);
endinterface

`default_nettype wire

[src/vrpv_div_step.sv]
// One restoring-division stage: decides one quotient bit of one lane.
// Depends on vrpv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrpv_div_step
    import vrpv_pkg::*;
#(
    parameter int WW    = 64,
    parameter int DNW   = 32,
    parameter int SHIFT = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WW-1:0]    i_rem,
    input  wire logic [DNW-1:0]   i_den,
    input  wire logic [QBITS-1:0] i_q,
    input  wire t_div_side        i_side,
    output      logic [WW-1:0]    o_rem,
    output      logic [DNW-1:0]   o_den,
    output      logic [QBITS-1:0] o_q,
    output      t_div_side        o_side
);

    logic [WW-1:0] w_sub;
    logic          w_take;

    assign w_sub  = WW'(i_den) << SHIFT;
    assign w_take = (i_rem >= w_sub);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_take ? (i_rem - w_sub) : i_rem;
            o_den  <= i_den;
            o_side <= i_side;
            o_q    <= i_q | (QBITS'(w_take) << SHIFT);
        end
    end

endmodule

`default_nettype wire

[src/vertex_rotate_project_viewport.sv]
// Vertex rotate, perspective project and viewport map: top level.
// Depends on vrpv_pkg, vrpv_vtx_if, vrpv_pix_if and vrpv_div_step.
//
// One vertex enters and one pixel leaves per clock unless the pipeline holds;
// a vertex passes through eleven stages of rotation, projection and magnitude
// set-up (a multiplier rank in every odd stage but the last), then one stage per
// quotient bit of the 17-bit restoring divider, then the saturating output
// register. The whole pipeline holds only when a result sits in the output
// register and the sink is not ready. Configuration registers feed the
// pipeline directly, so write them only while it is empty.
`timescale 1ns / 1ps
`default_nettype none

module vertex_rotate_project_viewport
    import vrpv_pkg::*;
#(
    parameter int COORD_BITS     = DEF_COORD_BITS,
    parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    vrpv_vtx_if.sink                  i_vtx,
    vrpv_pix_if.source                o_pix
);

    localparam int F    = TRIG_FRAC_BITS;
    localparam int TW   = TRIG_W;
    localparam int X0W  = COORD_BITS + 1;
    localparam int PW1  = TW + X0W;
    localparam int SW1  = PW1 + 1;
    localparam int AW1  = SW1 - F;
    localparam int PW2  = TW + AW1;
    localparam int SW2  = PW2 + 1;
    localparam int AW2  = SW2 - F;
    localparam int PW3  = TW + AW2;
    localparam int SW3  = PW3 + 1;
    localparam int AW3  = SW3 - F;
    localparam int ZW   = ((AW3 > TW) ? AW3 : TW) + 1;
    localparam int DW   = FOCAL_W + 1;
    localparam int KZW  = KW + ZW;
    localparam int DXW  = DW + AW2;
    localparam int DYW  = DW + AW3;
    localparam int NXW  = ((DXW > KZW) ? DXW : KZW) + 1;
    localparam int NYW  = ((DYW > KZW) ? DYW : KZW) + 1;
    localparam int MXW  = NXW + KW;
    localparam int MYW  = NYW + KW;
    localparam int DNW  = KZW;
    localparam int MW   = (MXW > MYW) ? MXW : MYW;
    localparam int WW   = ((MW > DNW + QBITS) ? MW : DNW + QBITS) + 1;
    localparam int NSTG = 11;

    // Configuration registers.
    logic signed [TW-1:0] r_s1, r_c1, r_s2, r_c2, r_s3, r_c3, r_off;
    logic [FOCAL_W-1:0]   r_focal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= RST_SIN;
            r_c1    <= RST_COS;
            r_s2    <= RST_SIN;
            r_c2    <= RST_COS;
            r_s3    <= RST_SIN;
            r_c3    <= RST_COS;
            r_off   <= RST_OFF;
            r_focal <= RST_FOCAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIN_FIRST:    r_s1    <= i_cfg_data;
                REG_COS_FIRST:    r_c1    <= i_cfg_data;
                REG_SIN_SECOND:   r_s2    <= i_cfg_data;
                REG_COS_SECOND:   r_c2    <= i_cfg_data;
                REG_SIN_THIRD:    r_s3    <= i_cfg_data;
                REG_COS_THIRD:    r_c3    <= i_cfg_data;
                REG_DEPTH_OFFSET: r_off   <= i_cfg_data;
                REG_FOCAL_LENGTH: r_focal <= i_cfg_data[FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless the output beat is held.
    logic r_ov;
    logic w_en;

    assign w_en        = !r_ov || o_pix.ready;
    assign i_vtx.ready = w_en;

    logic [NSTG-1:0] r_v;
    logic [QBITS-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v  <= {r_v[NSTG-2:0], i_vtx.valid};
            r_dv <= {r_dv[QBITS-2:0], r_v[NSTG-1]};
            r_ov <= r_dv[QBITS-1];
        end
    end

    // Stage 1: negate x, first rotation products.
    logic signed [X0W-1:0] w_x0, w_z0;
    logic signed [PW1-1:0] r1_cx, r1_sz, r1_sx, r1_cz;
    logic signed [COORD_BITS-1:0] r1_y;

    assign w_x0 = -X0W'(i_vtx.vx);
    assign w_z0 = X0W'(i_vtx.vz);

    // Stage 2: first rotation sums, floor shift.
    logic signed [SW1-1:0] w_xs1, w_zs1;
    logic signed [AW1-1:0] r2_xa, r2_za;
    logic signed [COORD_BITS-1:0] r2_y;

    assign w_xs1 = SW1'(r1_cx) - SW1'(r1_sz);
    assign w_zs1 = SW1'(r1_sx) + SW1'(r1_cz);

    // Stage 3: second rotation products.
    logic signed [PW2-1:0] r3_cxa, r3_sy, r3_cy, r3_sxa;
    logic signed [AW1-1:0] r3_za;

    // Stage 4: second rotation sums.
    logic signed [SW2-1:0] w_xs2, w_ys2;
    logic signed [AW2-1:0] r4_x, r4_ya;
    logic signed [AW1-1:0] r4_za;

    assign w_xs2 = SW2'(r3_cxa) + SW2'(r3_sy);
    assign w_ys2 = SW2'(r3_cy) - SW2'(r3_sxa);

    // Stage 5: third rotation products.
    logic signed [PW3-1:0] r5_cza, r5_sya, r5_sza, r5_cya;
    logic signed [AW2-1:0] r5_x;

    // Stage 6: third rotation sums and depth offset.
    logic signed [SW3-1:0] w_zs3, w_ys3;
    logic signed [AW3-1:0] w_z3, w_y3;
    logic signed [ZW-1:0]  r6_z;
    logic signed [AW3-1:0] r6_y;
    logic signed [AW2-1:0] r6_x;

    assign w_zs3 = SW3'(r5_cza) - SW3'(r5_sya);
    assign w_ys3 = SW3'(r5_sza) + SW3'(r5_cya);
    assign w_z3  = w_zs3[SW3-1:F];
    assign w_y3  = w_ys3[SW3-1:F];

    // Stage 7: projection products.
    logic signed [DW-1:0]  w_d;
    logic signed [DXW-1:0] r7_dx;
    logic signed [DYW-1:0] r7_dy;
    logic signed [KZW-1:0] r7_kzx, r7_kzy, r7_dnx, r7_dny;
    logic                  r7_zero;

    assign w_d = $signed({1'b0, r_focal});

    // Stage 8: numerators before screen scaling.
    logic signed [NXW-1:0] r8_nx;
    logic signed [NYW-1:0] r8_ny;
    logic signed [KZW-1:0] r8_dnx, r8_dny;
    logic                  r8_zero;

    // Stage 9: screen scaling.
    logic signed [MXW-1:0] r9_mx;
    logic signed [MYW-1:0] r9_my;
    logic signed [KZW-1:0] r9_dnx, r9_dny;
    logic                  r9_zero;

    // Stage 10: magnitudes and quotient signs.
    logic [MXW-1:0] w_amx;
    logic [MYW-1:0] w_amy;
    logic [DNW-1:0] w_adx, w_ady;
    logic [WW-1:0]  r10_rx, r10_ry;
    logic [DNW-1:0] r10_dx, r10_dy;
    logic           r10_nx, r10_ny, r10_zero;

    assign w_amx = r9_mx[MXW-1]  ? MXW'(-r9_mx)  : MXW'(r9_mx);
    assign w_amy = r9_my[MYW-1]  ? MYW'(-r9_my)  : MYW'(r9_my);
    assign w_adx = r9_dnx[KZW-1] ? DNW'(-r9_dnx) : DNW'(r9_dnx);
    assign w_ady = r9_dny[KZW-1] ? DNW'(-r9_dny) : DNW'(r9_dny);

    // Stage 11: flag quotients too large for the divider.
    logic [WW-1:0]  r11_rx, r11_ry;
    logic [DNW-1:0] r11_dx, r11_dy;
    t_div_side      r11_sx, r11_sy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cx <= r_c1 * w_x0;
            r1_sz <= r_s1 * w_z0;
            r1_sx <= r_s1 * w_x0;
            r1_cz <= r_c1 * w_z0;
            r1_y  <= i_vtx.vy;

            r2_xa <= w_xs1[SW1-1:F];
            r2_za <= w_zs1[SW1-1:F];
            r2_y  <= r1_y;

            r3_cxa <= r_c2 * r2_xa;
            r3_sy  <= r_s2 * r2_y;
            r3_cy  <= r_c2 * r2_y;
            r3_sxa <= r_s2 * r2_xa;
            r3_za  <= r2_za;

            r4_x  <= w_xs2[SW2-1:F];
            r4_ya <= w_ys2[SW2-1:F];
            r4_za <= r3_za;

            r5_cza <= r_c3 * r4_za;
            r5_sya <= r_s3 * r4_ya;
            r5_sza <= r_s3 * r4_za;
            r5_cya <= r_c3 * r4_ya;
            r5_x   <= r4_x;

            r6_z <= ZW'(w_z3) + ZW'(r_off);
            r6_y <= w_y3;
            r6_x <= r5_x;

            r7_dx   <= w_d * r6_x;
            r7_dy   <= w_d * r6_y;
            r7_kzx  <= K_X_CTR * r6_z;
            r7_kzy  <= K_Y_CTR * r6_z;
            r7_dnx  <= K_X_DEN * r6_z;
            r7_dny  <= K_Y_DEN * r6_z;
            r7_zero <= (r6_z == '0);

            r8_nx   <= NXW'(r7_dx) + NXW'(r7_kzx);
            r8_ny   <= NYW'(r7_dy) + NYW'(r7_kzy);
            r8_dnx  <= r7_dnx;
            r8_dny  <= r7_dny;
            r8_zero <= r7_zero;

            r9_mx   <= r8_nx * K_X_SCR;
            r9_my   <= r8_ny * K_Y_SCR;
            r9_dnx  <= r8_dnx;
            r9_dny  <= r8_dny;
            r9_zero <= r8_zero;

            r10_rx   <= WW'(w_amx);
            r10_ry   <= WW'(w_amy);
            r10_dx   <= w_adx;
            r10_dy   <= w_ady;
            r10_nx   <= r9_mx[MXW-1] ^ r9_dnx[KZW-1];
            r10_ny   <= r9_my[MYW-1] ^ r9_dny[KZW-1];
            r10_zero <= r9_zero;

            r11_rx      <= r10_rx;
            r11_ry      <= r10_ry;
            r11_dx      <= r10_dx;
            r11_dy      <= r10_dy;
            r11_sx.neg  <= r10_nx;
            r11_sx.ovf  <= (r10_rx >= (WW'(r10_dx) << QBITS));
            r11_sx.zero <= r10_zero;
            r11_sy.neg  <= r10_ny;
            r11_sy.ovf  <= (r10_ry >= (WW'(r10_dy) << QBITS));
            r11_sy.zero <= r10_zero;
        end
    end

    // Divider: one quotient bit per stage, most significant first.
    logic [WW-1:0]    w_rx [0:QBITS];
    logic [WW-1:0]    w_ry [0:QBITS];
    logic [DNW-1:0]   w_dx [0:QBITS];
    logic [DNW-1:0]   w_dy [0:QBITS];
    logic [QBITS-1:0] w_qx [0:QBITS];
    logic [QBITS-1:0] w_qy [0:QBITS];
    t_div_side        w_sx [0:QBITS];
    t_div_side        w_sy [0:QBITS];

    assign w_rx[0] = r11_rx;
    assign w_ry[0] = r11_ry;
    assign w_dx[0] = r11_dx;
    assign w_dy[0] = r11_dy;
    assign w_qx[0] = '0;
    assign w_qy[0] = '0;
    assign w_sx[0] = r11_sx;
    assign w_sy[0] = r11_sy;

    for (genvar g = 0; g < QBITS; g++) begin : g_div
        vrpv_div_step #(
            .WW    (WW),
            .DNW   (DNW),
            .SHIFT (QBITS - 1 - g)
        ) u_step_x (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rx[g]),
            .i_den  (w_dx[g]),
            .i_q    (w_qx[g]),
            .i_side (w_sx[g]),
            .o_rem  (w_rx[g+1]),
            .o_den  (w_dx[g+1]),
            .o_q    (w_qx[g+1]),
            .o_side (w_sx[g+1])
        );

        vrpv_div_step #(
            .WW    (WW),
            .DNW   (DNW),
            .SHIFT (QBITS - 1 - g)
        ) u_step_y (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_ry[g]),
            .i_den  (w_dy[g]),
            .i_q    (w_qy[g]),
            .i_side (w_sy[g]),
            .o_rem  (w_ry[g+1]),
            .o_den  (w_dy[g+1]),
            .o_q    (w_qy[g+1]),
            .o_side (w_sy[g+1])
        );
    end

    // Output register: apply sign, saturate, zero-depth override.
    t_div_side        w_fx, w_fy;
    logic [QBITS-1:0] w_qfx, w_qfy;
    logic             w_cx, w_cy;
    logic [PIX_W-1:0] w_px, w_py;

    assign w_fx  = w_sx[QBITS];
    assign w_fy  = w_sy[QBITS];
    assign w_qfx = w_qx[QBITS];
    assign w_qfy = w_qy[QBITS];

    always_comb begin
        if (w_fx.neg) begin
            w_cx = w_fx.ovf || (w_qfx > PIX_NEG_MAX);
            w_px = w_cx ? PIX_NEG_MAX[PIX_W-1:0] : PIX_W'(-w_qfx);
        end else begin
            w_cx = w_fx.ovf || (w_qfx > PIX_POS_MAX);
            w_px = w_cx ? PIX_POS_MAX[PIX_W-1:0] : w_qfx[PIX_W-1:0];
        end
        if (w_fy.neg) begin
            w_cy = w_fy.ovf || (w_qfy > PIX_NEG_MAX);
            w_py = w_cy ? PIX_NEG_MAX[PIX_W-1:0] : PIX_W'(-w_qfy);
        end else begin
            w_cy = w_fy.ovf || (w_qfy > PIX_POS_MAX);
            w_py = w_cy ? PIX_POS_MAX[PIX_W-1:0] : w_qfy[PIX_W-1:0];
        end
    end

    logic signed [PIX_W-1:0] r_px, r_py;
    logic                    r_zero, r_clip;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= w_fx.zero;
            r_clip <= !w_fx.zero && (w_cx || w_cy);
            r_px   <= w_fx.zero ? '0 : w_px;
            r_py   <= w_fx.zero ? '0 : w_py;
        end
    end

    assign o_pix.valid      = r_ov;
    assign o_pix.pixel_x    = r_px;
    assign o_pix.pixel_y    = r_py;
    assign o_pix.depth_zero = r_zero;
    assign o_pix.clipped    = r_clip;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for vertex_rotate_project_viewport: directed and random vertices,
// checked against a behavioral projection model. Depends on vrpv_pkg and both channel interfaces.
`timescale 1ns / 1ps

module tb_top;
    import vrpv_pkg::*;

    localparam int LATENCY   = 29;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1400;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               dz;
        logic               clip;
    } t_pixel;

    typedef struct {
        logic signed [11:0] vx;
        logic signed [11:0] vy;
        logic signed [11:0] vz;
        logic               known;
        t_pixel             pix;
    } t_vec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    vrpv_vtx_if #(.COORD_BITS(12)) vtx ();
    vrpv_pix_if pix ();

    vertex_rotate_project_viewport DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_vtx(vtx.sink), .o_pix(pix.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [15:0] shadow_regs [8];

    t_pixel pending_pixels [$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_off = 0;
    int     quiet_cycles = 0;

    function automatic longint floor_q14(longint v);
        return v >>> 14;
    endfunction

    function automatic longint clamp16(longint v, ref logic flag);
        if (v > 32767) begin
            flag = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            flag = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic t_pixel project_vertex(logic signed [11:0] vx, logic signed [11:0] vy,
                                              logic signed [11:0] vz);
        longint s1, c1, s2, c2, s3, c3, off, d, x, y, z, xa, za, ya, px, py;
        t_pixel r;
        logic clip;
        s1 = $signed(shadow_regs[REG_SIN_FIRST]);
        c1 = $signed(shadow_regs[REG_COS_FIRST]);
        s2 = $signed(shadow_regs[REG_SIN_SECOND]);
        c2 = $signed(shadow_regs[REG_COS_SECOND]);
        s3 = $signed(shadow_regs[REG_SIN_THIRD]);
        c3 = $signed(shadow_regs[REG_COS_THIRD]);
        off = $signed(shadow_regs[REG_DEPTH_OFFSET]);
        d = shadow_regs[REG_FOCAL_LENGTH][11:0];
        x = -longint'(vx);
        y = vy;
        z = vz;
        clip = 1'b0;
        xa = floor_q14(c1 * x - s1 * z);
        za = floor_q14(s1 * x + c1 * z);
        x = floor_q14(c2 * xa + s2 * y);
        ya = floor_q14(c2 * y - s2 * xa);
        z = floor_q14(c3 * za - s3 * ya) + off;
        y = floor_q14(s3 * za + c3 * ya);
        r.dz = (z == 0);
        px = 0;
        py = 0;
        if (!r.dz) begin
            // SystemVerilog integer division truncates toward zero.
            px = clamp16(((d * x + 399 * z) * 639) / (799 * z), clip);
            py = clamp16(((d * y + 299 * z) * 479) / (599 * z), clip);
        end
        r.px = px[15:0];
        r.py = py[15:0];
        r.clip = clip;
        return r;
    endfunction

    // One write beat, then the enable is cleared before the task returns, so it never toggles twice in one step.
    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_regs[idx] = (idx == REG_FOCAL_LENGTH) ? {4'h0, value[11:0]} : value;
        @(posedge i_clk);
    endtask

    // Stops offering vertices and waits for the pipeline to drain.
    task automatic drain();
        vtx.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_vertex(logic signed [11:0] vx, logic signed [11:0] vy,
                               logic signed [11:0] vz, logic known, t_pixel typed);
        t_pixel p;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            vtx.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx.valid <= 1'b1;
        vtx.vx <= vx;
        vtx.vy <= vy;
        vtx.vz <= vz;
        p = known ? typed : project_vertex(vx, vy, vz);
        do @(posedge i_clk); while (!vtx.ready);
        pending_pixels.push_back(p);
    endtask

    task automatic send_random(int n);
        t_pixel none;
        none = '{default: '0};
        repeat (n) begin
            send_vertex(12'($urandom), 12'($urandom), 12'($urandom), 1'b0, none);
        end
    endtask

    task automatic random_angles();
        write_reg(REG_SIN_FIRST, 16'($urandom_range(32768, 0) - 16384));
        write_reg(REG_COS_FIRST, 16'($urandom_range(32768, 0) - 16384));
        write_reg(REG_SIN_SECOND, 16'($urandom_range(32768, 0) - 16384));
        write_reg(REG_COS_SECOND, 16'($urandom_range(32768, 0) - 16384));
        write_reg(REG_SIN_THIRD, 16'($urandom_range(32768, 0) - 16384));
        write_reg(REG_COS_THIRD, 16'($urandom_range(32768, 0) - 16384));
        write_reg(REG_DEPTH_OFFSET, 16'($urandom_range(6000, 0) - 3000));
        write_reg(REG_FOCAL_LENGTH, 16'($urandom_range(4095, 1)));
    endtask

    // Receiver: random stalls plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pix.ready <= 1'b0;
        end else begin
            pix.ready <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && pix.valid && pix.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with no expected result");
                errors++;
            end else begin
                e = pending_pixels.pop_front();
                if (pix.pixel_x !== e.px) begin
                    $error("pixel_x expected %0d actual %0d", e.px, pix.pixel_x);
                    errors++;
                end
                if (pix.pixel_y !== e.py) begin
                    $error("pixel_y expected %0d actual %0d", e.py, pix.pixel_y);
                    errors++;
                end
                if (pix.depth_zero !== e.dz) begin
                    $error("depth_zero expected %0d actual %0d", e.dz, pix.depth_zero);
                    errors++;
                end
                if (pix.clipped !== e.clip) begin
                    $error("clipped expected %0d actual %0d", e.clip, pix.clipped);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if ((vtx.valid && vtx.ready) || (pix.valid && pix.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    // Directed rows; known rows carry their result, the rest use the predictor.
    t_vec directed [] = '{
        '{12'sd0, 12'sd0, 12'sd0, 1'b1, '{16'sd319, 16'sd239, 1'b0, 1'b0}},
        '{12'sd0, 12'sd0, 12'sd150, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{12'sd2047, 12'sd2047, 12'sd2047, 1'b0, '{default: '0}},
        '{-12'sd2048, -12'sd2048, -12'sd2048, 1'b0, '{default: '0}},
        '{12'sd2047, -12'sd2048, 12'sd151, 1'b0, '{default: '0}},
        '{-12'sd2048, 12'sd2047, 12'sd149, 1'b0, '{default: '0}},
        '{12'sd1, 12'sd1, 12'sd151, 1'b0, '{default: '0}},
        '{12'sd100, -12'sd100, 12'sd0, 1'b0, '{default: '0}},
        '{-12'sd1, 12'sd0, 12'sd2047, 1'b0, '{default: '0}},
        '{12'sd0, -12'sd1, -12'sd2048, 1'b0, '{default: '0}},
        '{12'sd1365, -12'sd1366, 12'sd1000, 1'b0, '{default: '0}},
        '{-12'sd1366, 12'sd1365, 12'sd200, 1'b0, '{default: '0}}
    };

    initial begin
        t_pixel none;
        none = '{default: '0};
        vtx.valid = 1'b0;
        vtx.vx = '0;
        vtx.vy = '0;
        vtx.vz = '0;
        shadow_regs = '{RST_SIN, RST_COS, RST_SIN, RST_COS, RST_SIN, RST_COS, RST_OFF,
                        16'(RST_FOCAL)};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_vertex(directed[i].vx, directed[i].vy, directed[i].vz,
                        directed[i].known, directed[i].pix);

        // Extreme register settings: full negative trig, smallest and largest focus.
        drain();
        write_reg(REG_SIN_FIRST, 16'h8000);
        write_reg(REG_COS_FIRST, 16'h7FFF);
        write_reg(REG_SIN_SECOND, 16'hC000);
        write_reg(REG_COS_SECOND, 16'h4000);
        write_reg(REG_SIN_THIRD, 16'h4000);
        write_reg(REG_COS_THIRD, 16'hC000);
        write_reg(REG_DEPTH_OFFSET, 16'h7FFF);
        write_reg(REG_FOCAL_LENGTH, 16'h0FFF);
        send_vertex(12'sd2047, -12'sd2048, 12'sd2047, 1'b0, none);
        send_vertex(-12'sd2048, 12'sd2047, -12'sd2048, 1'b0, none);
        drain();
        write_reg(REG_DEPTH_OFFSET, 16'h8000);
        write_reg(REG_FOCAL_LENGTH, 16'hF000);
        send_random(40);
        drain();
        write_reg(REG_FOCAL_LENGTH, 16'd1);
        write_reg(REG_DEPTH_OFFSET, 16'd0);
        send_random(40);

        send_idle_pct = 9;
        recv_idle_pct = 87;
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            random_angles();
            send_random(N_RANDOM / 9);
        end

        send_idle_pct = 87;
        recv_idle_pct = 9;
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            random_angles();
            send_random(N_RANDOM / 9);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        // Identity rotation so depth near zero is hit often.
        write_reg(REG_SIN_FIRST, RST_SIN);
        write_reg(REG_COS_FIRST, RST_COS);
        write_reg(REG_SIN_SECOND, RST_SIN);
        write_reg(REG_COS_SECOND, RST_COS);
        write_reg(REG_SIN_THIRD, RST_SIN);
        write_reg(REG_COS_THIRD, RST_COS);
        write_reg(REG_DEPTH_OFFSET, RST_OFF);
        hold_off = 300;
        repeat (N_RANDOM / 6) send_vertex(12'($urandom), 12'($urandom),
                                          12'($urandom_range(160, 140)), 1'b0, none);
        for (int ph = 0; ph < 2; ph++) begin
            drain();
            random_angles();
            send_random(N_RANDOM / 9);
        end

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
